// ===== rtl/smallest_absent_key_finder_core_assert.svh =====
// Assertion macros for the RTL of the smallest absent key finder.
`ifndef SMALLEST_ABSENT_KEY_FINDER_CORE_ASSERT_SVH
`define SMALLEST_ABSENT_KEY_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAKF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sakf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SAKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sakf: next-cycle check failed");

`endif

// ===== rtl/sakf_pkg.sv =====
`default_nettype none

package sakf_pkg;

    // Fixed field widths of the ports.
    localparam int KEY_W = 16;
    localparam int CFG_W = 5;
    localparam int REQ_W = 2;

    // Key length after reset.
    localparam logic [CFG_W-1:0] KEY_LEN_RESET = 5'd16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // One memory row holds the marks of a sibling pair: bit 0 the even node, bit 1 the odd.
    typedef logic [1:0] mark_pair_t;

    localparam mark_pair_t PAIR_EMPTY = 2'b00;
    localparam mark_pair_t PAIR_EVEN  = 2'b01;
    localparam mark_pair_t PAIR_ODD   = 2'b10;
    localparam mark_pair_t PAIR_FULL  = 2'b11;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CLEAR   = 6'b000010,
        ST_I_READ  = 6'b000100,
        ST_I_WRITE = 6'b001000,
        ST_Q_CHECK = 6'b010000,
        ST_Q_STEP  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sakf_mark_ram.sv =====
`default_nettype none

module sakf_mark_ram #(
    parameter int ADDR_W = 16
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [ADDR_W-1:0]        waddr,
    input  sakf_pkg::mark_pair_t    wdata,
    input  wire [ADDR_W-1:0]        raddr,
    output sakf_pkg::mark_pair_t    rdata
);
    import sakf_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    mark_pair_t mem [DEPTH];
    mark_pair_t rdata_reg;

    // Simple dual-port memory; a read is registered and returns the old contents in the next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/smallest_absent_key_finder_core.sv =====
`default_nettype none

// Channel      Direction  Signals                               Transfer when
// request      in         start, req_type, key, busy            start && !busy
// result       out        done, smallest_free, none_free        done (one cycle, no stall)
// key length   in         cfg_wr_en, cfg_wr_data                cfg_wr_en
//
// Insert does one read, then one read-modify-write per tree level,
// climbing while both siblings are saturated. Query does a root check, then
// one memory read per level, where each address follows from the data just read.
// Clear, and the pass after reset, write one sibling-pair row per cycle, all 2**KEY_BITS
// rows in turn; busy is high throughout, and key length writes are still taken.
// The result strobe lasts one cycle and the receiver cannot hold it off.

module smallest_absent_key_finder_core #(
    parameter int KEY_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire [sakf_pkg::REQ_W-1:0]   req_type,
    input  wire [sakf_pkg::KEY_W-1:0]   key,
    input  wire                         cfg_wr_en,
    input  wire [sakf_pkg::CFG_W-1:0]   cfg_wr_data,
    output logic                        done,
    output logic [sakf_pkg::KEY_W-1:0]  smallest_free,
    output logic                        none_free
);
    import sakf_pkg::*;

    // Node n of the tree lives in row n >> 1, bit n & 1; the root is bit 1 of row 0.
    localparam int ROW_W  = KEY_BITS;
    localparam int NODE_W = KEY_BITS + 1;
    localparam int LEN_W  = $clog2(KEY_BITS + 1);

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_len_reg;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [ROW_W-1:0]     result_reg, result_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [ROW_W-1:0]     sweep_reg, sweep_next;
    logic                 done_reg, done_next;
    logic                 none_free_reg, none_free_next;
    logic [KEY_W-1:0]     smallest_free_reg, smallest_free_next;

    logic                 accept;
    logic [LEN_W-1:0]     len_used;
    logic [ROW_W-1:0]     key_ext;
    logic [NODE_W-1:0]    lead_bit;
    logic [NODE_W-1:0]    ins_node;
    logic [NODE_W-1:0]    step_node;
    logic [ROW_W-1:0]     step_result;
    mark_pair_t           new_pair;

    logic                 mem_we;
    logic [ROW_W-1:0]     mem_waddr;
    mark_pair_t           mem_wdata;
    logic [ROW_W-1:0]     mem_raddr;
    mark_pair_t           mem_rdata;

    sakf_mark_ram #(
        .ADDR_W (ROW_W)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // The key length is clamped to 1..KEY_BITS when a request is taken.
    always_comb
    begin
        if (cfg_len_reg == '0)
        begin
            len_used = LEN_W'(1);
        end
        else if (32'(cfg_len_reg) > KEY_BITS)
        begin
            len_used = LEN_W'(KEY_BITS);
        end
        else
        begin
            len_used = LEN_W'(cfg_len_reg);
        end
    end

    // Leaf node of the inserted key: a leading one above the low L key bits.
    assign key_ext  = ROW_W'(key);
    assign lead_bit = NODE_W'(1) << len_used;
    assign ins_node = lead_bit | (NODE_W'(key_ext) & (lead_bit - NODE_W'(1)));

    // One query step: take the 1 branch only when the 0 child is saturated.
    assign step_node   = {node_reg[ROW_W-1:0], mem_rdata[0]};
    assign step_result = (result_reg << 1) | ROW_W'(mem_rdata[0]);

    // Mark the node on its row; the row read in the previous cycle is the current one.
    assign new_pair = mem_rdata | (node_reg[0] ? PAIR_ODD : PAIR_EVEN);

    always_comb
    begin
        state_next         = state_reg;
        node_next          = node_reg;
        result_next        = result_reg;
        cnt_next           = cnt_reg;
        sweep_next         = sweep_reg;
        done_next          = 1'b0;
        none_free_next     = none_free_reg;
        smallest_free_next = smallest_free_reg;
        mem_we             = 1'b0;
        mem_waddr          = ROW_W'(node_reg >> 1);
        mem_wdata          = PAIR_EMPTY;
        mem_raddr          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Row 0 is read throughout idle, so the root mark is ready for a query.
                mem_raddr = '0;
                if (accept)
                begin
                    case (req_type)
                        REQ_INSERT:
                        begin
                            node_next  = ins_node;
                            state_next = ST_I_READ;
                        end
                        REQ_QUERY:
                        begin
                            node_next   = NODE_W'(1);
                            result_next = '0;
                            cnt_next    = len_used;
                            state_next  = ST_Q_CHECK;
                        end
                        REQ_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = PAIR_EMPTY;
                sweep_next = sweep_reg + ROW_W'(1);
                if (sweep_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_I_READ:
            begin
                mem_raddr  = ROW_W'(node_reg >> 1);
                state_next = ST_I_WRITE;
            end

            ST_I_WRITE:
            begin
                // The parent row is read while this row is written; the two coincide only when row 0 is written.
                mem_we    = 1'b1;
                mem_waddr = ROW_W'(node_reg >> 1);
                mem_wdata = new_pair;
                mem_raddr = ROW_W'(node_reg >> 2);
                if (new_pair == PAIR_FULL && mem_waddr != '0)
                begin
                    node_next = node_reg >> 1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_Q_CHECK:
            begin
                mem_raddr = node_reg[ROW_W-1:0];
                if (mem_rdata[1])
                begin
                    done_next          = 1'b1;
                    none_free_next     = 1'b1;
                    smallest_free_next = '0;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    state_next = ST_Q_STEP;
                end
            end

            ST_Q_STEP:
            begin
                // The next row follows straight from the data just read.
                mem_raddr   = step_node[ROW_W-1:0];
                node_next   = step_node;
                result_next = step_result;
                cnt_next    = cnt_reg - LEN_W'(1);
                if (cnt_reg == LEN_W'(1))
                begin
                    done_next          = 1'b1;
                    none_free_next     = 1'b0;
                    smallest_free_next = KEY_W'(step_result);
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // After reset the memory is swept clean before the first request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            cfg_len_reg <= KEY_LEN_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                cfg_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg          <= node_next;
        result_reg        <= result_next;
        cnt_reg           <= cnt_next;
        none_free_reg     <= none_free_next;
        smallest_free_reg <= smallest_free_next;
    end

    assign done          = done_reg;
    assign none_free     = none_free_reg;
    assign smallest_free = smallest_free_reg;

`include "smallest_absent_key_finder_core_assert.svh"

    // A saturated root ends a query at once with the all-present flag.
    `SAKF_ASSERT_NEXT(a_root_full, clk, rst_n, (state_reg == ST_Q_CHECK) && mem_rdata[1], done && none_free)

    // The all-present flag always comes with a zero key.
    `SAKF_ASSERT_IMPL(a_full_zero, clk, rst_n, done && none_free, smallest_free == '0)

    // The memory is never written while the block waits for a request.
    `SAKF_ASSERT_IMPL(a_idle_no_write, clk, rst_n, !busy, !mem_we)

    // An insert never marks the unused node 0.
    `SAKF_ASSERT_IMPL(a_no_node_zero, clk, rst_n, (state_reg == ST_I_WRITE) && (mem_waddr == '0), !mem_wdata[0])

    // A taken query goes to the root check in the next cycle.
    `SAKF_ASSERT_NEXT(a_query_start, clk, rst_n, accept && (req_type == REQ_QUERY), state_reg == ST_Q_CHECK)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import sakf_pkg::*;

    // The block under test is built with its default key width.
    localparam int KEY_BITS      = 16;
    localparam int NODE_COUNT    = 1 << (KEY_BITS + 1);

    // Sizing of the run.
    // A clear, and the pass after reset, each sweep all 2**KEY_BITS rows. That dominates the
    // slowest correct run (about seven passes), so the limit is several times that.
    localparam int RANDOM_ITEMS  = 825;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PERCENT  = 29;
    localparam int CLEAR_BUDGET  = 5;
    localparam int REPORT_MAX    = 10;

    // The request code that the block must ignore.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // One query result, as the block reports it.
    typedef struct packed {
        logic [KEY_W-1:0] free_key;
        logic             all_taken;
    } free_result_t;

    // A row of the directed table either writes the key length or issues one request.
    typedef enum logic {
        ROW_REQ,
        ROW_LEN
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [REQ_W-1:0] req;
        logic [KEY_W-1:0] item_key;
        logic [CFG_W-1:0] len;
        logic             pinned;
        free_result_t     res;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [REQ_W-1:0]  req_type = REQ_INSERT;
    logic [KEY_W-1:0]  key = '0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = KEY_LEN_RESET;
    logic              done;
    logic [KEY_W-1:0]  smallest_free;
    logic              none_free;

    // Our own copy of the saturation tree and of the key length register.
    bit                sat_marks [NODE_COUNT];
    logic [CFG_W-1:0]  key_len_reg = KEY_LEN_RESET;

    // Query results that the block still owes us, oldest first.
    free_result_t      free_expect_q [$];

    int                fail_count = 0;
    int                cycle_count = 0;
    bit                gaps_on = 1'b1;

    // Directed table. Rows that are pinned carry a result that is obvious on sight: an empty
    // store, a full key space, or a single inserted key. The rest go through the predictor.
    dir_row_t dir_rows [25] = '{
        // Right after reset the store is empty; the key field of a query is ignored.
        '{ROW_REQ, REQ_QUERY,  16'hFFFF, 5'd0,  1'b1, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'h0000, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0001, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'hFFFF, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        // The unused request code must give no result and leave the store alone.
        '{ROW_REQ, REQ_UNUSED, 16'hFFFF, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        // A length of zero acts as one; the wide key is masked down to its last bit.
        '{ROW_LEN, REQ_INSERT, 16'h0000, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'hFFFE, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0001, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'h0001, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0000, 1'b1}},
        // The two short keys cover the whole space at the longest length as well.
        '{ROW_LEN, REQ_INSERT, 16'h0000, 5'd31, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0000, 1'b1}},
        '{ROW_REQ, REQ_CLEAR,  16'h5A5A, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0000, 1'b0}},
        // Fill a two-bit key space out of order.
        '{ROW_LEN, REQ_INSERT, 16'h0000, 5'd2,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'h0003, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'h0001, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'h0000, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_INSERT, 16'hFFFE, 5'd0,  1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0000, 1'b1}},
        // A length above the key width acts as the key width.
        '{ROW_LEN, REQ_INSERT, 16'h0000, 5'd17, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_REQ, REQ_QUERY,  16'h0000, 5'd0,  1'b1, '{16'h0000, 1'b1}}
    };

    smallest_absent_key_finder_core #(
        .KEY_BITS      (KEY_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .key           (key),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .smallest_free (smallest_free),
        .none_free     (none_free)
    );

    always #1 clk = ~clk;

    // The key length in use: the register clamped to 1..KEY_BITS.
    function automatic int unsigned eff_len(input logic [CFG_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > KEY_BITS)
            return KEY_BITS;
        return v;
    endfunction

    // Mark the leaf that the key selects at the current length, then climb toward the root
    // for as long as both siblings are saturated.
    function automatic void mark_key(input logic [KEY_W-1:0] k);
        int unsigned len;
        int unsigned node;
        len  = eff_len(key_len_reg);
        node = (1 << len) | (k & ((1 << len) - 1));
        sat_marks[node] = 1'b1;
        while (node > 1 && sat_marks[node] && sat_marks[node ^ 1])
        begin
            node = node >> 1;
            sat_marks[node] = 1'b1;
        end
    endfunction

    // Walk down from the root, taking the 0 branch unless it is saturated. The path taken
    // spells the smallest key that is still free. This does not change the tree.
    function automatic free_result_t lowest_free();
        free_result_t r;
        int unsigned  len;
        int unsigned  node;
        int unsigned  i;
        bit           b;
        r = '0;
        if (sat_marks[1])
        begin
            r.all_taken = 1'b1;
            return r;
        end
        len  = eff_len(key_len_reg);
        node = 1;
        for (i = 0; i < len; i++)
        begin
            b          = sat_marks[node << 1];
            node       = (node << 1) | b;
            r.free_key = {r.free_key[KEY_W-2:0], b};
        end
        return r;
    endfunction

    // Write the key length only while the block is idle. Inserts and clears leave nothing
    // to wait for in the result queue, so after the queue drains we let an insert finish,
    // then wait for busy to drop, which also covers a clear that is still sweeping.
    task automatic set_key_length(input logic [CFG_W-1:0] v);
        start <= 1'b0;
        while (free_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        key_len_reg = v;
    endtask

    // Offer one request and hold it until the block takes the transfer, then update our
    // tree. Idle cycles before the request carry random junk on the request fields.
    task automatic issue(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] k,
                         input bit use_pinned, input free_result_t pinned_res);
        free_result_t r;
        int unsigned  n;
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            start    <= 1'b0;
            req_type <= REQ_W'($urandom_range(3));
            key      <= KEY_W'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= req;
        key      <= k;
        // busy is read right after the edge, so it is the value the block saw at that edge.
        do
            @(posedge clk);
        while (busy);
        case (req)
            REQ_INSERT: mark_key(k);
            REQ_CLEAR:
            begin
                for (n = 0; n < NODE_COUNT; n++)
                    sat_marks[n] = 1'b0;
            end
            REQ_QUERY:
            begin
                r = use_pinned ? pinned_res : lowest_free();
                free_expect_q.insert(free_expect_q.size(), r);
            end
            default: ;
        endcase
    endtask

    // Result monitor. A strobe lasts one cycle and cannot be held off, so every cycle with
    // done high is a transfer that must match the oldest outstanding query.
    always @(posedge clk)
    begin : result_check
        free_result_t got;
        free_result_t want;
        if (rst_n && done)
        begin
            got.free_key  = smallest_free;
            got.all_taken = none_free;
            if (free_expect_q.size() == 0)
            begin
                if (fail_count < REPORT_MAX)
                    $display("%0t: result with no query outstanding: free=%h none=%b",
                             $realtime, got.free_key, got.all_taken);
                fail_count++;
            end
            else
            begin
                want = free_expect_q.pop_front();
                if (got.free_key !== want.free_key || got.all_taken !== want.all_taken)
                begin
                    if (fail_count < REPORT_MAX)
                        $display("%0t: mismatch: free exp %h got %h, none exp %b got %b",
                                 $realtime, want.free_key, got.free_key,
                                 want.all_taken, got.all_taken);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned      n_rand;
        int unsigned      phase;
        int unsigned      n_items;
        int unsigned      i;
        int unsigned      roll;
        int unsigned      clears_left;
        int unsigned      len_now;
        logic [CFG_W-1:0] len_v;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] mask;
        logic [REQ_W-1:0] req;
        free_result_t     near;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_LEN)
                set_key_length(dir_rows[r].len);
            else
                issue(dir_rows[r].req, dir_rows[r].item_key, dir_rows[r].pinned,
                      dir_rows[r].res);
        end

        // Random part, in phases of one key length each. The store is kept across phases
        // so that keys inserted at one length shape the answers at another. Each length
        // change drains every outstanding result first. The third phase runs with no
        // idle cycles at all. Short lengths fill the space quickly, so they get short phases,
        // and a saturated root is answered with a clear one time in five while the budget lasts.
        n_rand      = 0;
        phase       = 0;
        clears_left = CLEAR_BUDGET;
        while (n_rand < RANDOM_ITEMS)
        begin
            case (phase)
                0:       len_v = 5'd16;
                1:       len_v = 5'd31;
                2:       len_v = 5'd17;
                3:       len_v = 5'd0;
                default: len_v = ($urandom_range(1) == 0) ? CFG_W'($urandom_range(31))
                                                          : CFG_W'($urandom_range(1, 5));
            endcase
            set_key_length(len_v);
            gaps_on = (phase != 2);
            len_now = eff_len(len_v);
            n_items = (len_now <= 3) ? $urandom_range(4, 12) : $urandom_range(40, 90);
            mask    = KEY_W'((1 << len_now) - 1);
            for (i = 0; i < n_items && n_rand < RANDOM_ITEMS; i++)
            begin
                roll = $urandom_range(99);
                k    = KEY_W'($urandom);
                if (clears_left > 0 && ((sat_marks[1] && roll < 20) ||
                                        $urandom_range(999) < 2))
                begin
                    req = REQ_CLEAR;
                    clears_left--;
                end
                else if (roll < 3)
                begin
                    req = REQ_UNUSED;
                end
                else if (roll < 55)
                begin
                    // Often insert at or just past the smallest free key, so that the free
                    // key keeps moving; bits above the length stay random.
                    req  = REQ_INSERT;
                    near = lowest_free();
                    if (!near.all_taken && $urandom_range(99) < 45)
                        k = ((near.free_key + KEY_W'($urandom_range(2))) & mask) | (k & ~mask);
                end
                else
                begin
                    req = REQ_QUERY;
                end
                issue(req, k, 1'b0, '0);
                n_rand++;
            end
            phase++;
        end

        start <= 1'b0;
        while (free_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sakf_pkg.sv
rtl/sakf_mark_ram.sv
rtl/smallest_absent_key_finder_core.sv
tb/tb.sv
